>>> hw/rtl/fermion_annihilate_split_spin_basis_defines.svh
// assertion macros used by the top-level rtl file
`ifndef FERMION_ANNIHILATE_SPLIT_SPIN_BASIS_DEFINES_SVH
`define FERMION_ANNIHILATE_SPLIT_SPIN_BASIS_DEFINES_SVH

// condition a implies condition b on the same edge
`define FASB_ASSERT_IMPL(lbl, clk_s, rst_s, cond_a, cond_b) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (cond_a) |-> (cond_b)) \
    else $error("assertion failed: implication");

// condition must never hold
`define FASB_ASSERT_NEVER(lbl, clk_s, rst_s, cond_a) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond_a)) \
    else $error("assertion failed: forbidden condition");

`endif

>>> hw/rtl/fasb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fasb_pkg;

  localparam int LABEL_W          = 28;
  localparam int ORB_W            = 5;
  localparam int CFG_W            = 5;
  localparam int CHOOSE_W         = 30;
  localparam int TAB_MAX          = 32;
  localparam int MAX_ORBITALS_DEF = 16;

  localparam logic [CFG_W-1:0] NUM_ORBITALS_RST = 5'd8;
  localparam logic [CFG_W-1:0] UP_COUNT_RST     = 5'd4;
  localparam logic [CFG_W-1:0] DOWN_COUNT_RST   = 5'd4;

  // register indexes
  localparam logic [1:0] REG_NUM_ORBITALS = 2'd0;
  localparam logic [1:0] REG_UP_COUNT     = 2'd1;
  localparam logic [1:0] REG_DOWN_COUNT   = 2'd2;

  // word in the divider stages
  typedef struct packed {
    logic                ok;
    logic                down;
    logic [ORB_W-1:0]    t;
    logic [LABEL_W-1:0]  label;
    logic [LABEL_W-1:0]  quo;
    logic [CHOOSE_W-1:0] rem;
  } div_t;

  // word in the unrank stages
  typedef struct packed {
    logic                ok;
    logic                down;
    logic                hit;
    logic                par;
    logic [ORB_W-1:0]    t;
    logic [CFG_W-1:0]    k;
    logic [LABEL_W-1:0]  r;
    logic [CHOOSE_W-1:0] acc;
    logic [LABEL_W-1:0]  keep;
  } unr_t;

  // binomial coefficient, evaluated at elaboration only
  function automatic logic [CHOOSE_W-1:0] choose_c(input int n, input int k);
    longint row [0:TAB_MAX];
    int     i;
    int     j;
    for (i = 0; i <= TAB_MAX; i++) row[i] = 0;
    row[0] = 1;
    for (i = 1; i <= n; i++) begin
      for (j = i; j >= 1; j--) row[j] = row[j] + row[j-1];
    end
    if (k < 0 || k > n || n > TAB_MAX) return '0;
    return row[k][CHOOSE_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fasb_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface fasb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/fasb_item_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface fasb_item_if;
  logic        valid;
  logic        ready;
  logic [4:0]  orbital;
  logic [27:0] state_label;
  modport source (output valid, output orbital, output state_label, input ready);
  modport sink (input valid, input orbital, input state_label, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/fasb_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface fasb_result_if;
  logic        valid;
  logic        ready;
  logic [27:0] new_label;
  logic        sign_odd;
  logic        nonzero;
  modport source (output valid, output new_label, output sign_odd, output nonzero,
                  input ready);
  modport sink (input valid, input new_label, input sign_odd, input nonzero,
                output ready);
endinterface
`default_nettype wire

>>> hw/rtl/fasb_unrank.sv
`timescale 1ns / 1ps
`default_nettype none
module fasb_unrank #(
  parameter int MAX_ORBITALS = fasb_pkg::MAX_ORBITALS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  fasb_pkg::unr_t                 in_data,
  input  logic [fasb_pkg::CFG_W-1:0]     num_orbitals,
  output logic                           out_valid,
  output fasb_pkg::unr_t                 out_data
);
  import fasb_pkg::*;

  localparam int NW = $clog2(MAX_ORBITALS + 1);

  logic pv [0:MAX_ORBITALS-1];
  unr_t pd [0:MAX_ORBITALS-1];

  // one stage per bit position, highest position first
  for (genvar s = 0; s < MAX_ORBITALS; s++) begin : g_stage
    localparam int I = MAX_ORBITALS - 1 - s;
    logic [CHOOSE_W-1:0] row [0:MAX_ORBITALS];
    logic                src_v;
    unr_t                src;
    unr_t                nxt;
    logic [CHOOSE_W-1:0] c_k;
    logic [CHOOSE_W-1:0] c_km1;
    logic [CHOOSE_W-1:0] r_ext;

    for (genvar kk = 0; kk <= MAX_ORBITALS; kk++) begin : g_row
      assign row[kk] = choose_c(I, kk);
    end

    if (s == 0) begin : g_first
      assign src_v = in_valid;
      assign src   = in_data;
    end else begin : g_next
      assign src_v = pv[s-1];
      assign src   = pd[s-1];
    end

    // compare rank with C(i,k), take the bit and fold it into the new rank
    always_comb begin
      nxt   = src;
      r_ext = CHOOSE_W'(src.r);
      c_k   = (int'(src.k) <= MAX_ORBITALS) ? row[NW'(src.k)] : '0;
      c_km1 = (src.k != '0 && int'(src.k) - 1 <= MAX_ORBITALS) ?
              row[NW'(src.k - 5'd1)] : '0;
      if (int'(num_orbitals) > I && src.k != '0 && r_ext >= c_k) begin
        nxt.r = LABEL_W'(r_ext - c_k);
        nxt.k = src.k - 5'd1;
        if (src.t == ORB_W'(I)) begin
          nxt.hit = 1'b1;
        end else if (ORB_W'(I) < src.t) begin
          nxt.acc = src.acc + c_k;
          nxt.par = ~src.par;
        end else begin
          nxt.acc = src.acc + c_km1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pv[s] <= 1'b0;
      end else if (en) begin
        pv[s] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pd[s] <= nxt;
      end
    end
  end

  assign out_valid = pv[MAX_ORBITALS-1];
  assign out_data  = pd[MAX_ORBITALS-1];

endmodule
`default_nettype wire

>>> hw/rtl/fermion_annihilate_split_spin_basis.sv
`timescale 1ns / 1ps
`default_nettype none
// path from accepted word to result word: one input stage, 28 restoring
// divider stages, one unrank stage per orbital, multiply stage and output
// register; one word per cycle when not stalled
// synchronous reset clears valid bits and loads L=8, up=4, down=4
// derived dimensions are registered in dup/ddn and then in dim after reset or
// a configuration write; a settle counter holds input off until they settle
`include "fermion_annihilate_split_spin_basis_defines.svh"
module fermion_annihilate_split_spin_basis #(
  parameter int MAX_ORBITALS = fasb_pkg::MAX_ORBITALS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  fasb_cfg_if.sink      cfg,
  fasb_item_if.sink     item,
  fasb_result_if.source result
);
  import fasb_pkg::*;

  localparam int NW         = $clog2(MAX_ORBITALS + 1);
  localparam int DIV_STAGES = LABEL_W;

  logic [CFG_W-1:0] num_orbitals;
  logic [CFG_W-1:0] up_count;
  logic [CFG_W-1:0] down_count;

  logic [CHOOSE_W-1:0]   ctab [0:MAX_ORBITALS][0:MAX_ORBITALS];
  logic [CHOOSE_W-1:0]   dup_c, ddn_c, dupm1_c;
  logic                  l_ok_c;
  logic [CFG_W-1:0]      um1;
  logic [CHOOSE_W-1:0]   dup, ddn, dupm1;
  logic                  l_ok;
  logic [2*CHOOSE_W-1:0] dim;
  logic [1:0]            settle;
  logic                  in_ok;

  logic en;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_orbitals <= NUM_ORBITALS_RST;
      up_count     <= UP_COUNT_RST;
      down_count   <= DOWN_COUNT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_NUM_ORBITALS: num_orbitals <= cfg.data;
        REG_UP_COUNT:     up_count     <= cfg.data;
        REG_DOWN_COUNT:   down_count   <= cfg.data;
        default: ;
      endcase
    end
  end

  // hold off input while the derived dimensions catch up
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= 2'd2;
    end else if (cfg.valid) begin
      settle <= 2'd2;
    end else if (settle != '0) begin
      settle <= settle - 2'd1;
    end
  end

  assign in_ok = settle == '0;

  // binomial table
  for (genvar n = 0; n <= MAX_ORBITALS; n++) begin : g_tn
    for (genvar k = 0; k <= MAX_ORBITALS; k++) begin : g_tk
      assign ctab[n][k] = choose_c(n, k);
    end
  end

  // sector dimensions from the configuration
  always_comb begin
    um1     = up_count - 5'd1;
    l_ok_c  = num_orbitals != '0 && int'(num_orbitals) <= MAX_ORBITALS;
    dup_c   = (l_ok_c && int'(up_count) <= MAX_ORBITALS) ?
              ctab[NW'(num_orbitals)][NW'(up_count)] : '0;
    ddn_c   = (l_ok_c && int'(down_count) <= MAX_ORBITALS) ?
              ctab[NW'(num_orbitals)][NW'(down_count)] : '0;
    dupm1_c = (l_ok_c && int'(um1) <= MAX_ORBITALS) ?
              ctab[NW'(num_orbitals)][NW'(um1)] : '0;
  end

  always_ff @(posedge clk) begin
    l_ok  <= l_ok_c;
    dup   <= dup_c;
    ddn   <= ddn_c;
    dupm1 <= dupm1_c;
    dim   <= dup * ddn;
  end

  // input stage: range check and target orbital
  logic dv [0:DIV_STAGES];
  div_t dd [0:DIV_STAGES];
  div_t s0_next;

  assign item.ready = en && in_ok;

  always_comb begin
    s0_next       = '0;
    s0_next.label = item.state_label;
    s0_next.down  = item.orbital >= num_orbitals;
    s0_next.t     = s0_next.down ? item.orbital - num_orbitals : item.orbital;
    s0_next.ok    = l_ok && dup != '0 && ddn != '0 &&
                    (2*CHOOSE_W)'(item.state_label) < dim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= item.valid && in_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= s0_next;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic [CHOOSE_W:0] sh;
    div_t              nxt;

    always_comb begin
      nxt = dd[s];
      sh  = {dd[s].rem, dd[s].label[LABEL_W-1-s]};
      if (sh >= {1'b0, dup}) begin
        nxt.rem                = CHOOSE_W'(sh - {1'b0, dup});
        nxt.quo[LABEL_W-1-s]   = 1'b1;
      end else begin
        nxt.rem = sh[CHOOSE_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s+1] <= 1'b0;
      end else if (en) begin
        dv[s+1] <= dv[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dd[s+1] <= nxt;
      end
    end
  end

  // pick the spin sector that the target lives in
  unr_t u_in;
  unr_t u_out;
  logic u_out_v;
  div_t dq;

  always_comb begin
    dq        = dd[DIV_STAGES];
    u_in      = '0;
    u_in.ok   = dq.ok;
    u_in.down = dq.down;
    u_in.t    = dq.t;
    u_in.r    = dq.down ? dq.quo : dq.rem[LABEL_W-1:0];
    u_in.keep = dq.down ? dq.rem[LABEL_W-1:0] : dq.quo;
    u_in.k    = dq.down ? down_count : up_count;
    u_in.par  = dq.down ? up_count[0] : 1'b0;
  end

  fasb_unrank #(
    .MAX_ORBITALS(MAX_ORBITALS)
  ) u_unrank (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (dv[DIV_STAGES]),
    .in_data     (u_in),
    .num_orbitals(num_orbitals),
    .out_valid   (u_out_v),
    .out_data    (u_out)
  );

  // multiply stage
  logic                  m_v;
  logic                  m_live;
  logic                  m_par;
  logic [2*CHOOSE_W-1:0] m_prod;
  logic [CHOOSE_W-1:0]   m_add;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (en) begin
      m_v <= u_out_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_live <= u_out.ok && u_out.hit;
      m_par  <= u_out.par;
      m_prod <= u_out.down ? u_out.acc * dup : CHOOSE_W'(u_out.keep) * dupm1;
      m_add  <= u_out.down ? CHOOSE_W'(u_out.keep) : u_out.acc;
    end
  end

  // output register
  logic [2*CHOOSE_W-1:0] sum;
  logic                  res_v;
  logic [LABEL_W-1:0]    res_label;
  logic                  res_odd;
  logic                  res_nz;

  assign sum = m_prod + (2*CHOOSE_W)'(m_add);
  assign en  = !res_v || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (en) begin
      res_v <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_label <= m_live ? sum[LABEL_W-1:0] : '0;
      res_odd   <= m_live && m_par;
      res_nz    <= m_live;
    end
  end

  assign result.valid     = res_v;
  assign result.new_label = res_label;
  assign result.sign_odd  = res_odd;
  assign result.nonzero   = res_nz;

  `FASB_ASSERT_IMPL(a_null_is_zero, clk, rst, res_v && !res_nz, res_label == '0 && !res_odd)
  `FASB_ASSERT_IMPL(a_stall_blocks_input, clk, rst, res_v && !result.ready, !item.ready)
  `FASB_ASSERT_NEVER(a_hit_needs_dim, clk, rst, res_v && res_nz && dim == '0)

endmodule
`default_nettype wire
